[rtl/adte_pkg.sv]
// shared types, constants and the pair parser for the ascii date/time to epoch core
package adte_pkg;

    localparam int TEXT_W  = 48;
    localparam int COUNT_W = 3;
    localparam int EPOCH_W = 33;
    localparam int PAIR_W  = 7;

    localparam logic [COUNT_W-1:0] FULL_COUNT = 3'd6;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // years 1999..2099 are taken in era 4, so yoe = 400 + yy (less one for jan/feb)
    localparam logic [8:0]  YOE_BASE     = 9'd400;
    // yoe / 100 with the leap at 400 folded in: three across all of 399..499
    localparam logic [2:0]  CENT_SUB     = 3'd3;
    localparam logic [8:0]  DAYS_PER_YR  = 9'd365;
    localparam logic [7:0]  MONTH_MUL    = 8'd153;
    localparam logic [1:0]  MONTH_ADD    = 2'd2;
    // era * 146097 - 719468 - 1 for era 4 and the doy offset
    localparam logic [18:0] DAY_OFFSET   = 19'd135081;
    // x / 5 == (x * 52429) >> 18 for x below 2**18
    localparam logic [15:0] RECIP5       = 16'd52429;
    localparam int          RECIP5_SHIFT = 18;
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [11:0] SECS_PER_HR  = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN = 6'd60;

    typedef struct packed {
        logic [PAIR_W-1:0] value;
        logic              neg;
    } pair_t;

    typedef struct packed {
        logic [PAIR_W-1:0] day;
        logic [PAIR_W-1:0] month;
        logic [PAIR_W-1:0] yy;
        logic [PAIR_W-1:0] hour;
        logic [PAIR_W-1:0] minute;
        logic [PAIR_W-1:0] second;
        logic              rej;
    } fields_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch_seconds;
        logic               rejected;
    } result_t;

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic pair_t parse_pair(input logic [7:0] c0, input logic [7:0] c1);
        pair_t             r;
        logic [PAIR_W-1:0] d0;
        logic [PAIR_W-1:0] d1;
        d0      = PAIR_W'(c0[3:0]);
        d1      = PAIR_W'(c1[3:0]);
        r.value = '0;
        r.neg   = 1'b0;
        if (c0 == CH_SPACE)
        begin
            if (c1 == CH_MINUS)
            begin
                r.neg = 1'b1;
            end
            else if (is_digit(c1))
            begin
                r.value = d1;
            end
        end
        else if ((c0 == CH_PLUS) || (c0 == CH_MINUS))
        begin
            r.neg = (c0 == CH_MINUS);
            if (is_digit(c1))
            begin
                r.value = d1;
            end
        end
        else if (is_digit(c0))
        begin
            if (is_digit(c1))
            begin
                r.value = PAIR_W'(d0 * PAIR_W'(10)) + d1;
            end
            else
            begin
                r.value = d0;
            end
        end
        return r;
    endfunction

endpackage

[rtl/adte_in_if.sv]
// input channel: date and time text with character counts
interface adte_in_if;
    logic                              valid;
    logic                              ready;
    logic [adte_pkg::TEXT_W-1:0]       date_text;
    logic [adte_pkg::COUNT_W-1:0]      date_count;
    logic [adte_pkg::TEXT_W-1:0]       time_text;
    logic [adte_pkg::COUNT_W-1:0]      time_count;

    modport source (output valid, date_text, date_count, time_text, time_count,
                    input ready);
    modport sink (input valid, date_text, date_count, time_text, time_count,
                  output ready);
endinterface

[rtl/adte_out_if.sv]
// output channel: epoch seconds and reject flag
interface adte_out_if;
    logic                              valid;
    logic                              ready;
    logic [adte_pkg::EPOCH_W-1:0]      epoch_seconds;
    logic                              rejected;

    modport source (output valid, epoch_seconds, rejected, input ready);
    modport sink (input valid, epoch_seconds, rejected, output ready);
endinterface

[rtl/adte_parse.sv]
// first pipeline stage: splits the text into pairs, converts them and flags rejects
module adte_parse (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [adte_pkg::TEXT_W-1:0]     date_text,
    input  logic [adte_pkg::COUNT_W-1:0]    date_count,
    input  logic [adte_pkg::TEXT_W-1:0]     time_text,
    input  logic [adte_pkg::COUNT_W-1:0]    time_count,
    output logic                            out_valid,
    input  logic                            out_ready,
    output adte_pkg::fields_t               fields
);

    adte_pkg::pair_t   p_day;
    adte_pkg::pair_t   p_month;
    adte_pkg::pair_t   p_yy;
    adte_pkg::pair_t   p_hour;
    adte_pkg::pair_t   p_minute;
    adte_pkg::pair_t   p_second;
    adte_pkg::fields_t fields_next;
    adte_pkg::fields_t fields_reg;
    logic              valid_reg;
    logic              short_cnt;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        p_day    = adte_pkg::parse_pair(date_text[47:40], date_text[39:32]);
        p_month  = adte_pkg::parse_pair(date_text[31:24], date_text[23:16]);
        p_yy     = adte_pkg::parse_pair(date_text[15:8],  date_text[7:0]);
        p_hour   = adte_pkg::parse_pair(time_text[47:40], time_text[39:32]);
        p_minute = adte_pkg::parse_pair(time_text[31:24], time_text[23:16]);
        p_second = adte_pkg::parse_pair(time_text[15:8],  time_text[7:0]);
        short_cnt = (date_count < adte_pkg::FULL_COUNT) || (time_count < adte_pkg::FULL_COUNT);
        fields_next.day    = p_day.value;
        fields_next.month  = p_month.value;
        fields_next.yy     = p_yy.value;
        fields_next.hour   = p_hour.value;
        fields_next.minute = p_minute.value;
        fields_next.second = p_second.value;
        fields_next.rej    = short_cnt || p_day.neg || p_month.neg || p_yy.neg
                             || p_hour.neg || p_minute.neg || p_second.neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            fields_reg <= fields_next;
        end
    end

    assign out_valid = valid_reg;
    assign fields    = fields_reg;

endmodule

[rtl/adte_calc.sv]
// four pipeline stages: day count by days-from-civil, then scaling to seconds
module adte_calc (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  adte_pkg::fields_t    fields,
    output logic                 out_valid,
    input  logic                 out_ready,
    output adte_pkg::result_t    result
);

    // stage 2: month numerator, year part, partial time
    logic        v2_reg;
    logic        en2;
    logic [13:0] mnum2_reg, mnum2_next;
    logic [17:0] ypart2_reg, ypart2_next;
    logic [6:0]  day2_reg;
    logic [18:0] hsec2_reg, hsec2_next;
    logic [12:0] msec2_reg, msec2_next;
    logic        rej2_reg;
    logic [6:0]  mp;
    logic [8:0]  yoe;
    logic        early;

    // stage 3: divide by five, day base, time of day
    logic        v3_reg;
    logic        en3;
    logic [11:0] mdays3_reg, mdays3_next;
    logic [17:0] base3_reg, base3_next;
    logic [18:0] tsec3_reg, tsec3_next;
    logic        rej3_reg;
    logic [29:0] mprod;

    // stage 4: day count
    logic        v4_reg;
    logic        en4;
    logic [15:0] days4_reg, days4_next;
    logic [18:0] tsec4_reg;
    logic        rej4_reg;
    logic [18:0] dsum;

    // stage 5: seconds
    logic        v5_reg;
    logic        en5;
    adte_pkg::result_t res5_reg, res5_next;
    logic [32:0] dprod;

    assign en5      = !v5_reg || out_ready;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign in_ready = en2;

    always_comb
    begin
        early = (fields.month <= 7'd2);
        if (early)
        begin
            mp = fields.month + 7'd9;
        end
        else
        begin
            mp = fields.month - 7'd3;
        end
        yoe  = adte_pkg::YOE_BASE + 9'(fields.yy) - 9'(early);
        mnum2_next  = 14'(mp) * 14'(adte_pkg::MONTH_MUL) + 14'(adte_pkg::MONTH_ADD);
        ypart2_next = 18'(yoe) * 18'(adte_pkg::DAYS_PER_YR) + 18'(yoe[8:2])
                      - 18'(adte_pkg::CENT_SUB);
        hsec2_next  = 19'(fields.hour) * 19'(adte_pkg::SECS_PER_HR);
        msec2_next  = 13'(fields.minute) * 13'(adte_pkg::SECS_PER_MIN)
                      + 13'(fields.second);
    end

    always_comb
    begin
        mprod       = 30'(mnum2_reg) * 30'(adte_pkg::RECIP5);
        mdays3_next = mprod[29:adte_pkg::RECIP5_SHIFT];
        base3_next  = ypart2_reg + 18'(day2_reg);
        tsec3_next  = hsec2_reg + 19'(msec2_reg);
    end

    always_comb
    begin
        dsum       = 19'(base3_reg) + 19'(mdays3_reg) - adte_pkg::DAY_OFFSET;
        days4_next = dsum[15:0];
    end

    always_comb
    begin
        dprod = 33'(days4_reg) * 33'(adte_pkg::SECS_PER_DAY);
        if (rej4_reg)
        begin
            res5_next.epoch_seconds = '0;
        end
        else
        begin
            res5_next.epoch_seconds = dprod + 33'(tsec4_reg);
        end
        res5_next.rejected = rej4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en2)
            begin
                v2_reg <= in_valid;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && in_valid)
        begin
            mnum2_reg  <= mnum2_next;
            ypart2_reg <= ypart2_next;
            day2_reg   <= fields.day;
            hsec2_reg  <= hsec2_next;
            msec2_reg  <= msec2_next;
            rej2_reg   <= fields.rej;
        end
        if (en3 && v2_reg)
        begin
            mdays3_reg <= mdays3_next;
            base3_reg  <= base3_next;
            tsec3_reg  <= tsec3_next;
            rej3_reg   <= rej2_reg;
        end
        if (en4 && v3_reg)
        begin
            days4_reg <= days4_next;
            tsec4_reg <= tsec3_reg;
            rej4_reg  <= rej3_reg;
        end
        if (en5 && v4_reg)
        begin
            res5_reg <= res5_next;
        end
    end

    assign out_valid = v5_reg;
    assign result    = res5_reg;

endmodule

[rtl/ascii_date_time_to_epoch_core.sv]
// top level of the ascii date/time to unix epoch converter
//
// din carries one item: six ascii date chars ddmmyy, six ascii time chars
// hhmmss (first char in the top byte) and a char count for each
// dout carries one result per item: seconds since 1970-01-01 utc with the
// year read as 2000 + yy, and a reject flag for a short count or a minus
// sign leading any pair (seconds are then zero)
// five register stages: pair parsing, constant products, divide by five
// by reciprocal, day count, day-to-second multiply with time of day
// one item per cycle is taken and given while dout.ready is high, set by
// the single pass through the five stages
// each stage holds its own valid bit and moves when the stage after it is
// empty or moving, so a stall on dout.ready backs up stage by stage and
// bubbles still get filled; din.ready drops only once every stage is full
// reset clears all valid bits; no item is in flight afterward
module ascii_date_time_to_epoch_core (
    input  logic        clk,
    input  logic        rst_n,
    adte_in_if.sink     din,
    adte_out_if.source  dout
);

    logic              p_valid;
    logic              p_ready;
    adte_pkg::fields_t p_fields;
    adte_pkg::result_t res;

    adte_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (din.valid),
        .in_ready   (din.ready),
        .date_text  (din.date_text),
        .date_count (din.date_count),
        .time_text  (din.time_text),
        .time_count (din.time_count),
        .out_valid  (p_valid),
        .out_ready  (p_ready),
        .fields     (p_fields)
    );

    adte_calc u_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_valid),
        .in_ready  (p_ready),
        .fields    (p_fields),
        .out_valid (dout.valid),
        .out_ready (dout.ready),
        .result    (res)
    );

    assign dout.epoch_seconds = res.epoch_seconds;
    assign dout.rejected      = res.rejected;

endmodule

[rtl/adte_checker.sv]
// port-level checks for the converter and their bind to the top level
module adte_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [adte_pkg::EPOCH_W-1:0] epoch_seconds,
    input  logic                         rejected
);

    localparam logic [adte_pkg::EPOCH_W-1:0] EPOCH_MAX = 33'd4500000000;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> epoch_seconds == '0)
        else $error("rejected item with nonzero seconds");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> epoch_seconds <= EPOCH_MAX)
        else $error("seconds out of range");

    a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result right after reset");

endmodule

bind ascii_date_time_to_epoch_core adte_checker u_adte_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (dout.valid),
    .out_ready     (dout.ready),
    .epoch_seconds (dout.epoch_seconds),
    .rejected      (dout.rejected)
);

[dv/tb_ascii_date_time_to_epoch_core.sv]
`timescale 1ns / 100ps
// testbench for the ascii date/time to epoch core: directed and random items checked in order
module tb_ascii_date_time_to_epoch_core;

    typedef struct {
        logic [adte_pkg::TEXT_W-1:0]  date_text;
        logic [adte_pkg::COUNT_W-1:0] date_count;
        logic [adte_pkg::TEXT_W-1:0]  time_text;
        logic [adte_pkg::COUNT_W-1:0] time_count;
    } stamp_t;

    logic clk;
    logic rst_n;

    adte_in_if  din_ch ();
    adte_out_if dout_ch ();

    ascii_date_time_to_epoch_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_ch),
        .dout  (dout_ch)
    );

    adte_pkg::result_t epoch_due_q[$];
    int      mismatch_count = 0;
    bit      src_idle_en    = 1'b0;
    bit      sink_stall_en  = 1'b0;
    int      hold_req       = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // atoi on one two-char pair
    function automatic longint pair_number(input logic [7:0] c0, input logic [7:0] c1,
                                           inout bit minus);
        logic [7:0] ch [2];
        int         i;
        longint     v;
        ch[0] = c0;
        ch[1] = c1;
        i     = 0;
        v     = 0;
        while (i < 2 && ch[i] == adte_pkg::CH_SPACE)
            i++;
        if (i < 2 && (ch[i] == adte_pkg::CH_PLUS || ch[i] == adte_pkg::CH_MINUS))
        begin
            if (ch[i] == adte_pkg::CH_MINUS)
                minus = 1'b1;
            i++;
        end
        while (i < 2 && ch[i] >= adte_pkg::CH_ZERO && ch[i] <= adte_pkg::CH_NINE)
        begin
            v = v * 10 + longint'(ch[i] - adte_pkg::CH_ZERO);
            i++;
        end
        return v;
    endfunction

    function automatic longint civil_day_number(input longint yr, input longint mon,
                                                input longint dom);
        longint era;
        longint yoe;
        longint mp;
        longint doy;
        longint doe;
        if (mon <= 2)
            yr = yr - 1;
        era = (yr >= 0 ? yr : yr - 399) / 400;
        yoe = yr - era * 400;
        mp  = mon + (mon > 2 ? -3 : 9);
        doy = (153 * mp + 2) / 5 + dom - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    function automatic adte_pkg::result_t expected_epoch(input stamp_t s);
        adte_pkg::result_t r;
        bit      minus;
        longint  day;
        longint  mon;
        longint  yr;
        longint  hr;
        longint  mi;
        longint  sc;
        longint  secs;
        r.epoch_seconds = '0;
        r.rejected      = 1'b1;
        if (s.date_count < adte_pkg::FULL_COUNT || s.time_count < adte_pkg::FULL_COUNT)
            return r;
        minus = 1'b0;
        day   = pair_number(s.date_text[47:40], s.date_text[39:32], minus);
        mon   = pair_number(s.date_text[31:24], s.date_text[23:16], minus);
        yr    = pair_number(s.date_text[15:8], s.date_text[7:0], minus) + 2000;
        hr    = pair_number(s.time_text[47:40], s.time_text[39:32], minus);
        mi    = pair_number(s.time_text[31:24], s.time_text[23:16], minus);
        sc    = pair_number(s.time_text[15:8], s.time_text[7:0], minus);
        if (minus)
            return r;
        secs = civil_day_number(yr, mon, day) * 86400 + hr * 3600 + mi * 60 + sc;
        if (secs < 0)
            secs = 0;
        r.epoch_seconds = secs[adte_pkg::EPOCH_W-1:0];
        r.rejected      = 1'b0;
        return r;
    endfunction

    function automatic stamp_t make_stamp(input logic [adte_pkg::TEXT_W-1:0] dt,
                                          input logic [adte_pkg::COUNT_W-1:0] dc,
                                          input logic [adte_pkg::TEXT_W-1:0] tt,
                                          input logic [adte_pkg::COUNT_W-1:0] tc);
        stamp_t s;
        s.date_text  = dt;
        s.date_count = dc;
        s.time_text  = tt;
        s.time_count = tc;
        return s;
    endfunction

    function automatic logic [15:0] digit_pair();
        logic [7:0] c0;
        logic [7:0] c1;
        c0 = adte_pkg::CH_ZERO + 8'($urandom_range(0, 9));
        c1 = adte_pkg::CH_ZERO + 8'($urandom_range(0, 9));
        return {c0, c1};
    endfunction

    function automatic logic [7:0] any_char();
        case ($urandom_range(0, 5))
            0: return adte_pkg::CH_SPACE;
            1: return adte_pkg::CH_PLUS;
            2: return adte_pkg::CH_MINUS;
            3: return adte_pkg::CH_ZERO + 8'($urandom_range(0, 9));
            4: return 8'h09;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] mixed_pair();
        logic [7:0] c0;
        logic [7:0] c1;
        if ($urandom_range(0, 1) == 0)
            return digit_pair();
        c0 = any_char();
        c1 = any_char();
        return {c0, c1};
    endfunction

    // mostly well-formed digits, then noisy pairs, short counts and raw bits
    function automatic stamp_t rand_stamp();
        stamp_t s;
        int     pick;
        pick         = $urandom_range(0, 99);
        s.date_count = adte_pkg::COUNT_W'($urandom_range(6, 7));
        s.time_count = adte_pkg::COUNT_W'($urandom_range(6, 7));
        s.date_text  = {digit_pair(), digit_pair(), digit_pair()};
        s.time_text  = {digit_pair(), digit_pair(), digit_pair()};
        if (pick >= 75 && pick < 87)
        begin
            s.date_text = {mixed_pair(), mixed_pair(), mixed_pair()};
            s.time_text = {mixed_pair(), mixed_pair(), mixed_pair()};
        end
        else if (pick >= 87 && pick < 93)
        begin
            s.date_count = adte_pkg::COUNT_W'($urandom_range(0, 7));
            s.time_count = adte_pkg::COUNT_W'($urandom_range(0, 7));
        end
        else if (pick >= 93)
        begin
            s.date_text  = adte_pkg::TEXT_W'({$urandom(), $urandom()});
            s.time_text  = adte_pkg::TEXT_W'({$urandom(), $urandom()});
            s.date_count = adte_pkg::COUNT_W'($urandom_range(0, 7));
            s.time_count = adte_pkg::COUNT_W'($urandom_range(0, 7));
        end
        return s;
    endfunction

    task automatic send_item(input stamp_t s);
        int gap;
        if (src_idle_en && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            din_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din_ch.valid      <= 1'b1;
        din_ch.date_text  <= s.date_text;
        din_ch.date_count <= s.date_count;
        din_ch.time_text  <= s.time_text;
        din_ch.time_count <= s.time_count;
        @(posedge clk);
        while (!din_ch.ready)
            @(posedge clk);
        epoch_due_q.push_back(expected_epoch(s));
    endtask

    task automatic wait_drained();
        din_ch.valid <= 1'b0;
        while (epoch_due_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic test_short_counts();
        send_item(make_stamp("150624", 3'd5, "123456", adte_pkg::FULL_COUNT));
        send_item(make_stamp("150624", adte_pkg::FULL_COUNT, "123456", 3'd5));
        send_item(make_stamp("150624", 3'd0, "123456", 3'd0));
        send_item(make_stamp("150624", 3'd7, "123456", 3'd7));
        send_item(make_stamp("150624", adte_pkg::FULL_COUNT, "123456", 3'd7));
    endtask

    task automatic test_field_extremes();
        send_item(make_stamp("000000", adte_pkg::FULL_COUNT, "000000", adte_pkg::FULL_COUNT));
        send_item(make_stamp("999999", adte_pkg::FULL_COUNT, "999999", adte_pkg::FULL_COUNT));
        send_item(make_stamp('0, adte_pkg::FULL_COUNT, '0, adte_pkg::FULL_COUNT));
        send_item(make_stamp('1, 3'd7, '1, 3'd7));
        send_item(make_stamp("010100", adte_pkg::FULL_COUNT, "000000", adte_pkg::FULL_COUNT));
        send_item(make_stamp("311299", adte_pkg::FULL_COUNT, "235959", adte_pkg::FULL_COUNT));
    endtask

    task automatic test_pair_forms();
        send_item(make_stamp(" 5+3 9", adte_pkg::FULL_COUNT, "  1a\t5", adte_pkg::FULL_COUNT));
        send_item(make_stamp("5-1-9+", adte_pkg::FULL_COUNT, "+ 3 +0", adte_pkg::FULL_COUNT));
        send_item(make_stamp("++07 1", adte_pkg::FULL_COUNT, "12 +5-", adte_pkg::FULL_COUNT));
    endtask

    task automatic test_minus_sign();
        send_item(make_stamp("-50101", adte_pkg::FULL_COUNT, "120000", adte_pkg::FULL_COUNT));
        send_item(make_stamp("01 -01", adte_pkg::FULL_COUNT, "120000", adte_pkg::FULL_COUNT));
        send_item(make_stamp("010101", adte_pkg::FULL_COUNT, "0000-0", adte_pkg::FULL_COUNT));
        send_item(make_stamp("010101", adte_pkg::FULL_COUNT, "12--00", adte_pkg::FULL_COUNT));
    endtask

    task automatic test_carry_values();
        send_item(make_stamp("000300", adte_pkg::FULL_COUNT, "000000", adte_pkg::FULL_COUNT));
        send_item(make_stamp("150000", adte_pkg::FULL_COUNT, "000000", adte_pkg::FULL_COUNT));
        send_item(make_stamp("011399", adte_pkg::FULL_COUNT, "996099", adte_pkg::FULL_COUNT));
    endtask

    task automatic test_random_mix();
        src_idle_en   = 1'b1;
        sink_stall_en = 1'b1;
        repeat (550) send_item(rand_stamp());
    endtask

    // long receiver hold while items keep coming
    task automatic test_backpressure();
        src_idle_en   = 1'b0;
        sink_stall_en = 1'b0;
        hold_req      = 80;
        repeat (40) send_item(rand_stamp());
        wait_drained();
    endtask

    task automatic test_drain_pause();
        src_idle_en   = 1'b1;
        sink_stall_en = 1'b1;
        repeat (20) send_item(rand_stamp());
        wait_drained();
        repeat (20) send_item(rand_stamp());
    endtask

    task automatic test_steady_stream();
        src_idle_en   = 1'b0;
        sink_stall_en = 1'b0;
        repeat (100) send_item(rand_stamp());
    endtask

    initial
    begin : result_sink
        int gap;
        dout_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                gap      = hold_req;
                hold_req = 0;
                dout_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
                dout_ch.ready <= 1'b1;
            end
            else if (sink_stall_en && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 16);
                dout_ch.ready <= 1'b0;
                repeat (gap - 1) @(posedge clk);
            end
            else
            begin
                dout_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        adte_pkg::result_t due;
        if (rst_n && dout_ch.valid && dout_ch.ready)
        begin
            if (epoch_due_q.size() == 0)
            begin
                report_mismatch("result with no item pending");
            end
            else
            begin
                due = epoch_due_q.pop_front();
                if (dout_ch.epoch_seconds !== due.epoch_seconds)
                    report_mismatch($sformatf("epoch_seconds %0d, wanted %0d",
                                              dout_ch.epoch_seconds, due.epoch_seconds));
                if (dout_ch.rejected !== due.rejected)
                    report_mismatch($sformatf("rejected %0b, wanted %0b",
                                              dout_ch.rejected, due.rejected));
            end
        end
    end

    initial
    begin : run_tests
        rst_n             <= 1'b0;
        din_ch.valid      <= 1'b0;
        din_ch.date_text  <= '0;
        din_ch.date_count <= '0;
        din_ch.time_text  <= '0;
        din_ch.time_count <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_short_counts();
        test_field_extremes();
        test_pair_forms();
        test_minus_sign();
        test_carry_values();
        test_random_mix();
        test_backpressure();
        test_drain_pause();
        test_steady_stream();
        wait_drained();
        if (mismatch_count == 0 && epoch_due_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
